// File: rtl/ats_pkg.sv
package ats_pkg;

  // Sample and packed register widths
  localparam int ADC_BITS    = 10;
  localparam int PACK_W      = 2 * ADC_BITS;
  localparam int NUM_AXES    = 3;
  localparam int TIME_W      = 32;
  localparam int CFG_INDEX_W = 4;

  // Divider: quotient of (s-min)*250/(max-min) never exceeds 250
  localparam int QUO_W     = 8;
  localparam int BIT_IDX_W = $clog2(QUO_W);
  localparam int NUM_W     = ADC_BITS + QUO_W;

  // Timing and scaling constants
  localparam int SAMPLE_PERIOD_MS = 100;
  localparam int SHAKE_HOLDOFF_MS = 500;
  localparam int SCALE_SPAN       = 250;
  localparam int TILT_OFFSET      = 127;
  localparam int TILT_ENTER       = 96;
  localparam int TILT_LEAVE       = 32;
  localparam logic signed [7:0] TILT_MIN = -8'sd127;

  // Running average: divide by ten through a reciprocal
  localparam int SUM_W       = 12;
  localparam int MAG_W       = 11;
  localparam int RECIP_10    = 6554;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = MAG_W + RECIP_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAL_X      = 4'd0,
    REG_CAL_Y      = 4'd1,
    REG_CAL_Z      = 4'd2,
    REG_WIN_X      = 4'd3,
    REG_WIN_Y      = 4'd4,
    REG_WIN_Z      = 4'd5,
    REG_TILT_EN    = 4'd6,
    REG_SHAKE_EN   = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TILT_LEVEL = 2'd0,
    TILT_NEG   = 2'd1,
    TILT_POS   = 2'd2
  } tilt_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_AVERAGE,
    ST_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic [ADC_BITS-1:0] raw_x;
    logic [ADC_BITS-1:0] raw_y;
    logic [ADC_BITS-1:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] scaled_x;
    logic signed [7:0] scaled_y;
    logic signed [7:0] scaled_z;
    logic signed [7:0] average_x;
    logic signed [7:0] average_y;
    logic signed [7:0] average_z;
    logic [1:0]        tilt_event_x;
    logic [1:0]        tilt_event_y;
    logic [1:0]        tilt_event_z;
    logic              shake_event;
  } out_item_t;

  // Sequencer to lane
  typedef struct packed {
    logic                 start;
    logic                 step;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 scale;
    logic                 average;
    logic                 tilt_en;
  } lane_ctl_t;

  // Lane to merge stage
  typedef struct packed {
    logic signed [7:0] scaled;
    logic signed [7:0] average;
    logic [1:0]        tilt_event;
    logic              outside;
  } lane_stat_t;

endpackage

// File: rtl/ats_lane.sv
module ats_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  ats_pkg::lane_ctl_t          ctl,
  input  logic [ats_pkg::ADC_BITS-1:0] raw,
  input  logic [ats_pkg::PACK_W-1:0]  cal,
  input  logic [ats_pkg::PACK_W-1:0]  window,
  output ats_pkg::lane_stat_t         stat
);
  import ats_pkg::*;

  logic [ADC_BITS-1:0] lo, hi, clamped, win_lo, win_hi;
  logic [NUM_W-1:0]    num_start, trial;
  logic [NUM_W-1:0]    rem;
  logic [QUO_W-1:0]    quo;
  logic [ADC_BITS-1:0] divisor;
  logic                degen;
  logic                outside_q;

  logic [QUO_W:0]        tilt_wide;
  logic signed [7:0]     tilt_val, tilt_q;
  logic signed [SUM_W-1:0] sum, sum_q;
  logic [MAG_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic [7:0]            q10;
  logic signed [7:0]     avg, avg_next;
  tilt_state_t           tilt_st, tilt_st_next;
  logic [1:0]            event_q, event_next;

  // Clamp the sample and form the dividend
  always_comb begin
    lo      = cal[ADC_BITS-1:0];
    hi      = cal[PACK_W-1:ADC_BITS];
    win_lo  = window[ADC_BITS-1:0];
    win_hi  = window[PACK_W-1:ADC_BITS];
    if (raw > hi) begin
      clamped = hi;
    end else if (raw < lo) begin
      clamped = lo;
    end else begin
      clamped = raw;
    end
    num_start = NUM_W'((NUM_W'(clamped) - NUM_W'(lo)) * NUM_W'(SCALE_SPAN));
    trial     = NUM_W'(divisor) << ctl.bit_idx;
  end

  // Restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem       <= num_start;
      quo       <= '0;
      divisor   <= hi - lo;
      degen     <= (hi <= lo);
      outside_q <= (raw < win_lo) || (raw > win_hi);
    end else if (ctl.step) begin
      if (rem >= trial) begin
        rem          <= rem - trial;
        quo[ctl.bit_idx] <= 1'b1;
      end
    end
  end

  // Truncate toward zero and start the average sum
  always_comb begin
    tilt_wide = {1'b0, quo} - (QUO_W+1)'(TILT_OFFSET)
              + (QUO_W+1)'((quo < QUO_W'(TILT_OFFSET)) && (rem != '0));
    tilt_val  = degen ? TILT_MIN : $signed(tilt_wide[7:0]);
    sum       = (SUM_W'(avg) <<< 3) + SUM_W'(avg) + SUM_W'(tilt_val);
  end

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      tilt_q <= tilt_val;
      sum_q  <= sum;
    end
  end

  // Divide the sum by ten and run the hysteresis
  always_comb begin
    mag  = MAG_W'(sum_q[SUM_W-1] ? -sum_q : sum_q);
    prod = PROD_W'(mag) * PROD_W'(RECIP_10);
    q10  = prod[RECIP_SHIFT +: 8];
    avg_next = sum_q[SUM_W-1] ? -$signed(q10) : $signed(q10);

    tilt_st_next = tilt_st;
    event_next   = TILT_LEVEL;
    if (ctl.tilt_en) begin
      if (tilt_q < -8'sd96 && tilt_st == TILT_LEVEL) begin
        tilt_st_next = TILT_NEG;
        event_next   = TILT_NEG;
      end else if (tilt_q > 8'(TILT_ENTER) && tilt_st == TILT_LEVEL) begin
        tilt_st_next = TILT_POS;
        event_next   = TILT_POS;
      end else if (tilt_q < 8'(TILT_LEAVE) && tilt_q > -8'sd32 && tilt_st != TILT_LEVEL) begin
        tilt_st_next = TILT_LEVEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg     <= '0;
      tilt_st <= TILT_LEVEL;
    end else if (ctl.average) begin
      avg     <= avg_next;
      tilt_st <= tilt_st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.average) begin
      event_q <= event_next;
    end
  end

  assign stat.scaled     = tilt_q;
  assign stat.average    = avg;
  assign stat.tilt_event = event_q;
  assign stat.outside    = outside_q;

endmodule

// File: rtl/ats_merge.sv
module ats_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  ats_pkg::lane_stat_t  stat [ats_pkg::NUM_AXES],
  input  logic                 shake_en,
  input  logic                 holdoff_ok,
  input  logic                 load,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ats_pkg::out_item_t   out_data,
  output logic                 room,
  output logic                 shook
);
  import ats_pkg::*;

  // Combine the lanes' window checks into one shake
  always_comb begin
    shook = shake_en && holdoff_ok && (stat[0].outside || stat[1].outside || stat[2].outside);
    room  = !out_valid || out_ready;
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.scaled_x     <= stat[0].scaled;
      out_data.scaled_y     <= stat[1].scaled;
      out_data.scaled_z     <= stat[2].scaled;
      out_data.average_x    <= stat[0].average;
      out_data.average_y    <= stat[1].average;
      out_data.average_z    <= stat[2].average;
      out_data.tilt_event_x <= stat[0].tilt_event;
      out_data.tilt_event_y <= stat[1].tilt_event;
      out_data.tilt_event_z <= stat[2].tilt_event;
      out_data.shake_event  <= shook;
    end
  end

endmodule

// File: rtl/accel_tilt_shake_detector_core.sv
// Accelerometer tilt and shake detector.
// Input channel (in_valid/in_ready/in_data) takes one request: a ms timestamp
// and one raw sample per axis. A request less than or equal to 100 ms after
// the last processed one is dropped without a result, and in_ready stays up.
// A processed request yields one result on out_valid/out_ready/out_data:
// scaled tilt, running average and tilt event per axis, and a shake flag.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write only while the block is idle. Unknown indexes are ignored.
// Three lanes work on X, Y and Z side by side; each owns a restoring divider
// that yields one quotient bit a cycle, so the divider sets the rate.
// Steps: a taken request runs DIVIDE, SCALE and AVERAGE, then EMIT, where the
// merge register loads the result and raises out_valid. The sequencer then
// returns to IDLE and takes the next request; a dropped one leaves it in IDLE.
// The output register frees the sequencer, so a new request is taken while
// a result still waits; a second result waits in the merge step until the
// receiver takes the first. Reset (rst, synchronous) clears the averages,
// tilt states and time stamps and restores the register defaults.
module accel_tilt_shake_detector_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ats_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ats_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ats_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ats_pkg::PACK_W-1:0]     cfg_data
);
  import ats_pkg::*;

  localparam logic [PACK_W-1:0] PACK_RESET = {{ADC_BITS{1'b1}}, {ADC_BITS{1'b0}}};

  fsm_state_t           state, state_next;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic [TIME_W-1:0]    last_sample_time, last_shake_time, now_q;
  logic [PACK_W-1:0]    cal [NUM_AXES];
  logic [PACK_W-1:0]    win [NUM_AXES];
  logic                 tilt_en, shake_en;
  logic                 process, start, load, room, shook, holdoff_ok;
  lane_ctl_t            ctl;
  lane_stat_t           stat [NUM_AXES];
  logic [ADC_BITS-1:0]  raw_lane [NUM_AXES];

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal[0]   <= PACK_RESET;
      cal[1]   <= PACK_RESET;
      cal[2]   <= PACK_RESET;
      win[0]   <= PACK_RESET;
      win[1]   <= PACK_RESET;
      win[2]   <= PACK_RESET;
      tilt_en  <= 1'b0;
      shake_en <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAL_X:    cal[0]   <= cfg_data;
        REG_CAL_Y:    cal[1]   <= cfg_data;
        REG_CAL_Z:    cal[2]   <= cfg_data;
        REG_WIN_X:    win[0]   <= cfg_data;
        REG_WIN_Y:    win[1]   <= cfg_data;
        REG_WIN_Z:    win[2]   <= cfg_data;
        REG_TILT_EN:  tilt_en  <= cfg_data[0];
        REG_SHAKE_EN: shake_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sample period gate and shake holdoff
  always_comb begin
    process    = (in_data.now_ms - last_sample_time) > TIME_W'(SAMPLE_PERIOD_MS);
    holdoff_ok = (now_q - last_shake_time) >= TIME_W'(SHAKE_HOLDOFF_MS);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid && process) state_next = ST_DIVIDE;
      ST_DIVIDE:  if (bit_idx == '0) state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_AVERAGE;
      ST_AVERAGE: state_next = ST_EMIT;
      ST_EMIT:    if (room) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = (state == ST_IDLE);
    start       = (state == ST_IDLE) && in_valid && process;
    load        = (state == ST_EMIT) && room;
    ctl.start   = start;
    ctl.step    = (state == ST_DIVIDE);
    ctl.bit_idx = bit_idx;
    ctl.scale   = (state == ST_SCALE);
    ctl.average = (state == ST_AVERAGE);
    ctl.tilt_en = tilt_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      bit_idx          <= '0;
      last_sample_time <= '0;
      last_shake_time  <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        bit_idx          <= BIT_IDX_W'(QUO_W - 1);
        last_sample_time <= in_data.now_ms;
      end else if (ctl.step) begin
        bit_idx <= bit_idx - 1'b1;
      end
      if (load && shook) begin
        last_shake_time <= now_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      now_q <= in_data.now_ms;
    end
  end

  assign raw_lane[0] = in_data.raw_x;
  assign raw_lane[1] = in_data.raw_y;
  assign raw_lane[2] = in_data.raw_z;

  // One lane per axis
  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
    ats_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .raw    (raw_lane[ax]),
      .cal    (cal[ax]),
      .window (win[ax]),
      .stat   (stat[ax])
    );
  end

  ats_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .stat       (stat),
    .shake_en   (shake_en),
    .holdoff_ok (holdoff_ok),
    .load       (load),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .room       (room),
    .shook      (shook)
  );

`ifndef ASSERT_OFF
  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result appeared outside the merge step");

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !process |=> state == ST_IDLE && $stable(last_sample_time))
    else $error("dropped request disturbed the sequencer");

  a_shake_time_on_load: assert property (@(posedge clk) disable iff (rst)
    !$stable(last_shake_time) |-> $past(rst) || ($past(load) && $past(shook)))
    else $error("shake time changed without a shake result");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import ats_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 900;
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  localparam logic [ADC_BITS-1:0]    ADC_TOP       = '1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = CFG_INDEX_W'(REG_SHAKE_EN + 1);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [PACK_W-1:0]      value;
    in_item_t               req;
    bit                     typed;
    out_item_t              want;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [PACK_W-1:0]      cfg_data  = '0;

  // Shadow copy of the registers and the per-axis state
  logic [PACK_W-1:0] cal_bounds [NUM_AXES];
  logic [PACK_W-1:0] shake_win [NUM_AXES];
  logic              tilt_en;
  logic              shake_en;
  logic [TIME_W-1:0] last_sample_ms;
  logic [TIME_W-1:0] last_shake_ms;
  logic signed [7:0] avg_state [NUM_AXES];
  tilt_state_t       tilt_state [NUM_AXES];

  out_item_t         pending_reports [$];
  stim_row_t         dir_rows [$];
  logic [TIME_W-1:0] stamp_ms = '0;
  int                mismatches = 0;
  int                reports_seen = 0;
  int                cycles = 0;
  int                in_burst = 0;

  accel_tilt_shake_detector_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[accel_tilt_shake_detector_core] ERROR");
      $finish;
    end
  end

  // Clamp to the calibration bounds, then map onto -127..123, truncating toward zero
  function automatic logic signed [7:0] scale_sample(input logic [ADC_BITS-1:0] s,
                                                     input logic [PACK_W-1:0] bounds);
    int lo, hi, c, n, d, q, r;
    lo = bounds[ADC_BITS-1:0];
    hi = bounds[PACK_W-1:ADC_BITS];
    c  = s;
    if (hi <= lo) return TILT_MIN;
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    n = (c - lo) * SCALE_SPAN;
    d = hi - lo;
    q = n / d;
    r = n % d;
    if (q >= TILT_OFFSET) return 8'(q - TILT_OFFSET);
    return 8'(q + (r != 0 ? 1 : 0) - TILT_OFFSET);
  endfunction

  // Work out the tilt report for one request; return 0 when it is dropped
  function automatic bit compute_report(input in_item_t req, output out_item_t rep);
    logic [ADC_BITS-1:0] raw [NUM_AXES];
    logic signed [7:0]   tilt [NUM_AXES];
    tilt_state_t         ev [NUM_AXES];
    logic [ADC_BITS-1:0] wlo, whi;
    bit                  shook;
    rep   = '0;
    shook = 1'b0;
    if (req.now_ms - last_sample_ms <= SAMPLE_PERIOD_MS) return 1'b0;
    last_sample_ms = req.now_ms;
    raw[0] = req.raw_x;
    raw[1] = req.raw_y;
    raw[2] = req.raw_z;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      tilt[ax]      = scale_sample(raw[ax], cal_bounds[ax]);
      avg_state[ax] = 8'((9 * int'(avg_state[ax]) + int'(tilt[ax])) / 10);
      ev[ax]        = TILT_LEVEL;
      // hysteresis: enter on the outer thresholds, leave inside the inner band
      if (tilt_en) begin
        if (tilt[ax] < -TILT_ENTER && tilt_state[ax] == TILT_LEVEL) begin
          tilt_state[ax] = TILT_NEG;
          ev[ax]         = TILT_NEG;
        end else if (tilt[ax] > TILT_ENTER && tilt_state[ax] == TILT_LEVEL) begin
          tilt_state[ax] = TILT_POS;
          ev[ax]         = TILT_POS;
        end else if (tilt[ax] < TILT_LEAVE && tilt[ax] > -TILT_LEAVE &&
                     tilt_state[ax] != TILT_LEVEL) begin
          tilt_state[ax] = TILT_LEVEL;
        end
      end
      // a detection restarts the holdoff, so later axes see it at once
      if (shake_en && req.now_ms - last_shake_ms >= SHAKE_HOLDOFF_MS) begin
        wlo = shake_win[ax][ADC_BITS-1:0];
        whi = shake_win[ax][PACK_W-1:ADC_BITS];
        if (raw[ax] < wlo || raw[ax] > whi) begin
          shook         = 1'b1;
          last_shake_ms = req.now_ms;
        end
      end
    end
    rep.scaled_x     = tilt[0];
    rep.scaled_y     = tilt[1];
    rep.scaled_z     = tilt[2];
    rep.average_x    = avg_state[0];
    rep.average_y    = avg_state[1];
    rep.average_z    = avg_state[2];
    rep.tilt_event_x = ev[0];
    rep.tilt_event_y = ev[1];
    rep.tilt_event_z = ev[2];
    rep.shake_event  = shook;
    return 1'b1;
  endfunction

  function automatic string fmt_report(input out_item_t r);
    return $sformatf("scaled %0d %0d %0d avg %0d %0d %0d tilt %0d %0d %0d shake %0d",
                     r.scaled_x, r.scaled_y, r.scaled_z, r.average_x, r.average_y,
                     r.average_z, r.tilt_event_x, r.tilt_event_y, r.tilt_event_z,
                     r.shake_event);
  endfunction

  // Compare one report with the oldest one outstanding
  task automatic check_report(input out_item_t got);
    out_item_t want;
    bit        bad;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("unexpected report: %s", fmt_report(got));
      return;
    end
    want = pending_reports.pop_front();
    bad  = (got.scaled_x !== want.scaled_x) || (got.scaled_y !== want.scaled_y) ||
           (got.scaled_z !== want.scaled_z) || (got.average_x !== want.average_x) ||
           (got.average_y !== want.average_y) || (got.average_z !== want.average_z) ||
           (got.tilt_event_x !== want.tilt_event_x) ||
           (got.tilt_event_y !== want.tilt_event_y) ||
           (got.tilt_event_z !== want.tilt_event_z) ||
           (got.shake_event !== want.shake_event);
    if (bad) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("report %0d mismatch", reports_seen);
        $display("  expected %s", fmt_report(want));
        $display("  actual   %s", fmt_report(got));
      end
    end
  endtask

  // Offer one request after a random gap; predict once it is taken
  task automatic send_req(input in_item_t req, input bit typed, input out_item_t want,
                          output bit produced);
    int        gap;
    out_item_t rep;
    if (in_burst > 0) begin
      gap = 0;
      in_burst--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 29) == 0) in_burst = 40;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    produced = compute_report(req, rep);
    if (produced) pending_reports.push_back(typed ? want : rep);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [PACK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_CAL_X, REG_CAL_Y, REG_CAL_Z: cal_bounds[index[1:0]] = value;
      REG_WIN_X, REG_WIN_Y, REG_WIN_Z: shake_win[2'(index - REG_WIN_X)] = value;
      REG_TILT_EN:  tilt_en  = value[0];
      REG_SHAKE_EN: shake_en = value[0];
      default: ;
    endcase
  endtask

  // Stop offering, wait for every report, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic stim_row_t req_row(input logic [TIME_W-1:0] now,
                                        input logic [ADC_BITS-1:0] x, y, z);
    stim_row_t row;
    row.kind       = ROW_REQ;
    row.index      = '0;
    row.value      = '0;
    row.req.now_ms = now;
    row.req.raw_x  = x;
    row.req.raw_y  = y;
    row.req.raw_z  = z;
    row.typed      = 1'b0;
    row.want       = '0;
    return row;
  endfunction

  // Fixed report with the same scaled value and average on all axes, no events
  function automatic stim_row_t typed_row(input logic [TIME_W-1:0] now,
                                          input logic [ADC_BITS-1:0] raw,
                                          input logic signed [7:0] sc, av);
    stim_row_t row;
    row                = req_row(now, raw, raw, raw);
    row.typed          = 1'b1;
    row.want.scaled_x  = sc;
    row.want.scaled_y  = sc;
    row.want.scaled_z  = sc;
    row.want.average_x = av;
    row.want.average_y = av;
    row.want.average_z = av;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                        input logic [PACK_W-1:0] value);
    stim_row_t row;
    row       = req_row('0, '0, '0, '0);
    row.kind  = ROW_CFG;
    row.index = index;
    row.value = value;
    return row;
  endfunction

  // Packed low/high pair: extremes, degenerate, random, one-step and ordered ranges
  function automatic logic [PACK_W-1:0] draw_pair();
    logic [ADC_BITS-1:0] a, b;
    a = ADC_BITS'($urandom_range(0, ADC_TOP));
    b = ADC_BITS'($urandom_range(0, ADC_TOP));
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {ADC_TOP, {ADC_BITS{1'b0}}};
      3: return {a, b};
      4: begin
        a = ADC_BITS'($urandom_range(0, ADC_TOP - 1));
        return {a + 1'b1, a};
      end
      default: return (a < b) ? {b, a} : {a, b};
    endcase
  endfunction

  function automatic logic [ADC_BITS-1:0] draw_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ADC_TOP;
      default: return ADC_BITS'($urandom_range(0, ADC_TOP));
    endcase
  endfunction

  // Mostly spaced past the sample period, some too close, some on the boundary, some jumps anywhere
  function automatic in_item_t draw_req();
    in_item_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) stamp_ms += $urandom_range(SAMPLE_PERIOD_MS + 1, 700);
    else if (pick < 80) stamp_ms += $urandom_range(0, SAMPLE_PERIOD_MS);
    else if (pick < 88) stamp_ms += SAMPLE_PERIOD_MS + pick[0];
    else stamp_ms = $urandom;
    req.now_ms = stamp_ms;
    req.raw_x  = draw_raw();
    req.raw_y  = draw_raw();
    req.raw_z  = draw_raw();
    return req;
  endfunction

  // Take reports with random stalls and two long hold-offs
  initial begin
    int stall;
    int out_burst;
    out_burst = 0;
    wait (rst === 1'b0);
    forever begin
      if (reports_seen == 150 || reports_seen == 500) begin
        stall = HOLD_CYCLES;
      end else if (out_burst > 0) begin
        stall = 0;
        out_burst--;
      end else begin
        stall = $urandom_range(0, 9);
        if ($urandom_range(0, 29) == 0) out_burst = 40;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_report(out_data);
      reports_seen++;
    end
  end

  initial begin
    stim_row_t         row;
    in_item_t          req;
    out_item_t         none;
    logic [PACK_W-1:0] fill;
    bit                produced;
    int                sent;
    none = '0;

    // register defaults and cleared state
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      cal_bounds[ax] = {ADC_TOP, {ADC_BITS{1'b0}}};
      shake_win[ax]  = {ADC_TOP, {ADC_BITS{1'b0}}};
      avg_state[ax]  = '0;
      tilt_state[ax] = TILT_LEVEL;
    end
    tilt_en        = 1'b0;
    shake_en       = 1'b0;
    last_sample_ms = '0;
    last_shake_ms  = '0;

    // defaults: too early, then bottom and top of the full calibration range
    dir_rows.push_back(req_row(32'd50, 10'd0, 10'd0, 10'd0));
    dir_rows.push_back(typed_row(32'd101, 10'd0, -8'sd127, -8'sd12));
    dir_rows.push_back(typed_row(32'd202, ADC_TOP, 8'sd123, 8'sd1));
    dir_rows.push_back(req_row(32'd302, 10'd5, 10'd6, 10'd7));
    dir_rows.push_back(req_row(32'd303, ADC_TOP, 10'd0, 10'd200));
    // tilt and shake on, inverted window on Z, degenerate Y, unknown indexes
    dir_rows.push_back(cfg_row(REG_TILT_EN, 20'd1));
    dir_rows.push_back(cfg_row(REG_SHAKE_EN, 20'd1));
    dir_rows.push_back(cfg_row(REG_WIN_X, {10'd900, 10'd100}));
    dir_rows.push_back(cfg_row(REG_WIN_Y, {10'd900, 10'd100}));
    dir_rows.push_back(cfg_row(REG_WIN_Z, {10'd0, ADC_TOP}));
    dir_rows.push_back(cfg_row(REG_CAL_Y, {10'd500, 10'd500}));
    dir_rows.push_back(cfg_row(REG_UNUSED_LO, '1));
    dir_rows.push_back(cfg_row(REG_UNUSED_HI, '0));
    // enter, hold, leave and re-enter tilt; shake holdoff
    dir_rows.push_back(req_row(32'd1000, 10'd0, 10'd512, ADC_TOP));
    dir_rows.push_back(req_row(32'd1200, ADC_TOP, 10'd0, 10'd0));
    dir_rows.push_back(req_row(32'd1600, 10'd512, 10'd0, 10'd0));
    dir_rows.push_back(req_row(32'd1700, ADC_TOP, ADC_TOP, ADC_TOP));
    // timestamp wrap
    dir_rows.push_back(req_row(32'hFFFF_FF00, 10'd0, ADC_TOP, 10'd512));
    dir_rows.push_back(req_row(32'h0000_0064, 10'd512, 10'd512, 10'd512));
    dir_rows.push_back(req_row(32'h0000_00C8, 10'd1, 10'd2, 10'd3));
    // one-step calibration, max below min, both features off
    dir_rows.push_back(cfg_row(REG_CAL_X, {10'd1, 10'd0}));
    dir_rows.push_back(cfg_row(REG_CAL_Z, {10'd0, ADC_TOP}));
    dir_rows.push_back(cfg_row(REG_TILT_EN, 20'd0));
    dir_rows.push_back(cfg_row(REG_SHAKE_EN, 20'd0));
    dir_rows.push_back(req_row(32'h0000_0200, 10'd0, 10'd1, ADC_TOP));
    dir_rows.push_back(req_row(32'h0000_0300, 10'd1, 10'd0, 10'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind == ROW_REQ) drain();
        write_reg(row.index, row.value);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_req(row.req, row.typed, row.want, produced);
      end
    end

    // random phases: all-zero registers, all-ones, random pairs with both enables on, then random settings
    sent = 0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      for (int r = REG_CAL_X; r <= REG_SHAKE_EN; r++) begin
        if (phase == 0) fill = '0;
        else if (phase == 1 || (phase == 2 && r >= REG_TILT_EN)) fill = '1;
        else if (r >= REG_TILT_EN) fill = PACK_W'($urandom);
        else fill = draw_pair();
        write_reg(CFG_INDEX_W'(r), fill);
      end
      write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                PACK_W'($urandom));
      cfg_valid <= 1'b0;
      while (sent < (phase + 1) * RANDOM_ITEMS / NUM_PHASES) begin
        req = draw_req();
        send_req(req, 1'b0, none, produced);
        sent++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[accel_tilt_shake_detector_core] OK");
    end else begin
      $display("[accel_tilt_shake_detector_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ats_pkg.sv
rtl/ats_lane.sv
rtl/ats_merge.sv
rtl/accel_tilt_shake_detector_core.sv
sim/tb.sv
